// ===== sv/sspan_pkg.sv =====
// Shared types, sizes and ring-slot arithmetic for the stock span block.
package sspan_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned PRICE_W     = 31;
  localparam int unsigned SPAN_W      = 16;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [SPAN_W-1:0]  span_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef struct packed {
    price_t price;
    span_t  span;
  } entry_t;

  localparam int unsigned ENTRY_W   = $bits(entry_t);
  localparam count_t      CNT_FULL  = CNT_W'(STACK_DEPTH);
  localparam addr_t       LAST_ADDR = ADDR_W'(STACK_DEPTH - 1);
  localparam span_t       SPAN_MAX  = '1;
  localparam span_t       SPAN_ONE  = SPAN_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_FILL = 3'b100
  } state_e;

  // Ring slot of stack position pos above the bottom pointer; base < depth and
  // pos <= depth, so one compare and subtract wraps it.
  function automatic addr_t slot_of(addr_t base, count_t pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(STACK_DEPTH)) begin
      sum = sum - (CNT_W+1)'(STACK_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/sspan_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module sspan_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/stock_span_monotonic_stack.sv =====
// Stock span unit: monotonic (price, span) stack held in a ring RAM.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------
//   in      | to block  | in_valid_i / in_ready_o    | price_i
//   out     | from block| out_valid_o / out_ready_i  | span_o, overflow_o
//
// Steps: an item that pops nothing passes accept, then compare+push.
//   Each popped entry adds a compare that folds its span and a fill state
//   that waits on the stack RAM read while the next entry down is fetched.
//   The pop that empties the stack adds no fill state, as nothing is fetched.
// The top of stack sits in a register, so only pops touch the RAM read port.
// Reset clears state, count, bottom pointer and output valid only; the RAM needs no clearing pass.
// The output register frees the input side: a new item is taken while a
// result still waits, and the push stalls only if that result is not yet taken.
module stock_span_monotonic_stack
  import sspan_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  price_t price_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output span_t  span_o,
  output logic   overflow_o
);

  state_e state_q, state_d;
  count_t count_q, count_d;
  addr_t  base_q, base_d;
  entry_t top_q, top_d;       // cached top of stack, valid while count_q != 0
  price_t price_q, price_d;   // item being worked on
  span_t  acc_q, acc_d;       // running span
  logic   flag_q, flag_d;
  logic   out_valid_q, out_valid_d;
  span_t  out_span_q, out_span_d;
  logic   out_flag_q, out_flag_d;

  logic   ram_we, ram_re;
  addr_t  ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  logic            pop_ok;
  logic            out_free;
  logic [SPAN_W:0] sum;
  logic            sum_sat;
  span_t           sum_span;

  sspan_ram #(
    .Width(ENTRY_W),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Fold the top entry's span into the running sum, saturating.
  assign sum      = {1'b0, acc_q} + {1'b0, top_q.span};
  assign sum_sat  = sum[SPAN_W];
  assign sum_span = sum_sat ? SPAN_MAX : sum[SPAN_W-1:0];
  assign pop_ok   = (count_q != '0) && (top_q.price <= price_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    base_d      = base_q;
    top_d       = top_q;
    price_d     = price_q;
    acc_d       = acc_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_span_d  = out_span_q;
    out_flag_d  = out_flag_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = slot_of(base_q, count_q);
    ram_raddr   = slot_of(base_q, count_q - count_t'(2));
    ram_wdata   = '{price: price_q, span: acc_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          price_d = price_i;
          acc_d   = SPAN_ONE;
          flag_d  = 1'b0;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (pop_ok) begin
          // Pop the top; fetch the next entry down if one remains.
          acc_d   = sum_span;
          flag_d  = flag_q | sum_sat;
          count_d = count_q - count_t'(1);
          if (count_q > count_t'(1)) begin
            ram_re  = 1'b1;
            state_d = S_FILL;
          end
        end else if (out_free) begin
          // Push; on a full stack drop the bottom entry, whose slot is reused.
          ram_we = 1'b1;
          top_d  = '{price: price_q, span: acc_q};
          if (count_q == CNT_FULL) begin
            base_d     = (base_q == LAST_ADDR) ? '0 : base_q + addr_t'(1);
            out_flag_d = 1'b1;
          end else begin
            count_d    = count_q + count_t'(1);
            out_flag_d = flag_q;
          end
          out_span_d  = acc_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_FILL: begin
        top_d   = ram_rdata;
        state_d = S_CMP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    price_q    <= price_d;
    acc_q      <= acc_d;
    flag_q     <= flag_d;
    out_span_q <= out_span_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o = out_valid_q;
  assign span_o      = out_span_q;
  assign overflow_o  = out_flag_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("stack count beyond depth");

  a_ram_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("stack RAM read and written in one cycle");

  a_fill_after_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> $past(state_q) == S_CMP)
    else $error("fill state not entered from compare");

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CMP)
    else $error("accepted item did not start compare");

  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> span_o != '0)
    else $error("zero span delivered");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the stock span unit with random handshake gaps.
module tb;
  import sspan_pkg::*;

  localparam price_t      PRICE_TOP  = '1;
  localparam int unsigned HANG_LIMIT = 20000;  // must outlast the deepest pop run
  localparam int unsigned RAND_ITEMS = 900;
  localparam int unsigned FILL_ITEMS = STACK_DEPTH + 6;
  localparam int unsigned DRAIN_WAIT = 20;

  typedef struct packed {
    span_t span;
    logic  ovf;
  } result_t;

  // One directed row: price, and an expected result where it is obvious.
  typedef struct packed {
    price_t price;
    logic   typed;
    span_t  span;
    logic   ovf;
  } step_row_t;

  typedef enum int {
    RUN_SCATTER,
    RUN_RISE,
    RUN_FALL,
    RUN_NARROW,
    RUN_EXTREME
  } run_kind_e;

  logic   clk = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  price_t price = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  span_t  span;
  logic   overflow;

  // Directed rows: empty stack, both price extremes, equal prices, pops of
  // several entries, alternating bit patterns.
  step_row_t steps [20] = '{
    '{price: '0,                  typed: 1'b1, span: 16'd1, ovf: 1'b0},
    '{price: PRICE_TOP,           typed: 1'b1, span: 16'd2, ovf: 1'b0},
    '{price: PRICE_TOP,           typed: 1'b1, span: 16'd3, ovf: 1'b0},
    '{price: '0,                  typed: 1'b1, span: 16'd1, ovf: 1'b0},
    '{price: '0,                  typed: 1'b1, span: 16'd2, ovf: 1'b0},
    '{price: 31'd1,               typed: 1'b1, span: 16'd3, ovf: 1'b0},
    '{price: 31'h4000_0000,       typed: 1'b1, span: 16'd4, ovf: 1'b0},
    '{price: PRICE_TOP,           typed: 1'b1, span: 16'd8, ovf: 1'b0},
    '{price: 31'd100,             typed: 1'b1, span: 16'd1, ovf: 1'b0},
    '{price: 31'd50,              typed: 1'b1, span: 16'd1, ovf: 1'b0},
    '{price: 31'd75,              typed: 1'b1, span: 16'd2, ovf: 1'b0},
    '{price: 31'd100,             typed: 1'b1, span: 16'd4, ovf: 1'b0},
    '{price: 31'h5555_5555,       typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: 31'h2AAA_AAAA,       typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: 31'h2AAA_AAAA,       typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: 31'h5555_5555,       typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: PRICE_TOP - 31'd1,   typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: 31'd1,               typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: '0,                  typed: 1'b0, span: '0,    ovf: 1'b0},
    '{price: PRICE_TOP,           typed: 1'b0, span: '0,    ovf: 1'b0}
  };

  entry_t    price_ladder[$];  // mirror of the block's monotonic stack, bottom first
  result_t   spans_due[$];     // results owed by the block, oldest first
  result_t   typed_due[$];     // per sent item: hand-typed result, if any
  logic      typed_flag[$];
  logic      idle_on = 1'b1;
  int        errors = 0;
  int        hang_cycles = 0;

  stock_span_monotonic_stack u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .price_i     (price),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .span_o      (span),
    .overflow_o  (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pop every entry priced at most p, fold the spans into a saturating sum,
  // drop the bottom entry if the ladder is still full, then push (p, sum).
  function automatic result_t span_of(input price_t p);
    int unsigned sum;
    result_t     r;
    entry_t      e;
    sum = 1;
    r.ovf = 1'b0;
    while (price_ladder.size() > 0 && price_ladder[$].price <= p) begin
      sum += price_ladder[$].span;
      if (sum > SPAN_MAX) begin
        sum = SPAN_MAX;
        r.ovf = 1'b1;
      end
      void'(price_ladder.pop_back());
    end
    if (price_ladder.size() >= STACK_DEPTH) begin
      void'(price_ladder.pop_front());
      r.ovf = 1'b1;
    end
    r.span = span_t'(sum);
    e.price = p;
    e.span = r.span;
    price_ladder.push_back(e);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!idle_on) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Present one item after an optional gap and hold it until accepted.
  task automatic send_price(input price_t p, input logic typed, input result_t hand);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_flag.push_back(typed);
    typed_due.push_back(hand);
    in_valid <= 1'b1;
    price    <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_free(input price_t p);
    send_price(p, 1'b0, '0);
  endtask

  // Stimulus: directed rows, a full-stack run, then random runs.
  initial begin
    int        sent;
    int        run_len;
    run_kind_e kind;
    price_t    p;
    int unsigned step;
    result_t   hand;

    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (steps[i]) begin
      hand.span = steps[i].span;
      hand.ovf  = steps[i].ovf;
      send_price(steps[i].price, steps[i].typed, hand);
    end

    // Overfill the stack with falling prices, then wipe it with the top price;
    // that span comes out short since the bottom entries were dropped.
    for (int k = 0; k < FILL_ITEMS; k++) begin
      send_free(PRICE_TOP - price_t'(k + 1));
    end
    send_free(PRICE_TOP);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind    = run_kind_e'($urandom_range(0, 4));
      run_len = $urandom_range(1, 30);
      idle_on = ($urandom_range(0, 3) != 0);
      p       = price_t'($urandom());
      step    = $urandom_range(1, 2000);
      for (int k = 0; k < run_len; k++) begin
        case (kind)
          RUN_SCATTER: begin
            p = price_t'($urandom());
          end
          RUN_RISE: begin
            p = (PRICE_TOP - p < step) ? PRICE_TOP : p + price_t'(step);
          end
          RUN_FALL: begin
            p = (p < step) ? '0 : p - price_t'(step);
          end
          RUN_NARROW: begin
            p = price_t'($urandom_range(0, 7));
          end
          default: begin
            p = $urandom_range(0, 1) ? PRICE_TOP : '0;
          end
        endcase
        send_free(p);
        sent++;
      end
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    // Drain: let the monitor log the last item, wait out every owed result,
    // then a short settle window.
    @(posedge clk);
    while (spans_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && spans_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: stall at random, then take results as they come.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_ni) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Monitor: predict on each accepted item, check each accepted result,
  // and count cycles with no handshake on either side.
  always @(posedge clk) begin : monitor_b
    result_t want;
    result_t hand;
    logic    typed;
    logic    moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        moved = 1'b1;
        want  = span_of(price);
        typed = (typed_flag.size() > 0) ? typed_flag.pop_front() : 1'b0;
        hand  = (typed_due.size() > 0) ? typed_due.pop_front() : '0;
        spans_due.push_back(typed ? hand : want);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (spans_due.size() == 0) begin
          $display("%0t: unexpected result: span %0d overflow %0b",
                   $time, span, overflow);
          errors++;
        end else begin
          want = spans_due.pop_front();
          if (span !== want.span) begin
            $display("%0t: span mismatch: expected %0d, actual %0d",
                     $time, want.span, span);
            errors++;
          end
          if (overflow !== want.ovf) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, want.ovf, overflow);
            errors++;
          end
        end
      end
      hang_cycles = moved ? 0 : hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
